// File: design/blend_block_index_walker_macros.svh
// ----------------------------------------------------------------------------
// Block index walker assertion macros
// Clocked assertion helpers shared by the walker modules. They expect the
// signals clk and arst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef BLEND_BLOCK_INDEX_WALKER_MACROS_SVH
`define BLEND_BLOCK_INDEX_WALKER_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BBIW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition must never be true at a clock edge out of reset
`define BBIW_ASSERT_NEVER(label, cond, msg) \
	`BBIW_ASSERT(label, !(cond), msg)
`else
`define BBIW_ASSERT(label, prop, msg)
`define BBIW_ASSERT_NEVER(label, cond, msg)
`endif
`endif

// File: design/bbiw_pkg.sv
// ----------------------------------------------------------------------------
// Block index walker package
// Shared types and constants: walk phases, status codes, file magics and
// the result record that travels from the parser through the queue.
// ----------------------------------------------------------------------------
package bbiw_pkg;

	// byte offset counter width (16 to 64)
	localparam int OFFSET_BITS = 32;

	// result queue between parser and output side
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// walk phases
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_BLOCK,
		PH_BODY,
		PH_DONE
	} phase_t;

	// final status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZSTD    = 3'd1;
	localparam logic [2:0] ST_GZIP    = 3'd2;
	localparam logic [2:0] ST_NO_SIG  = 3'd3;
	localparam logic [2:0] ST_NO_SDNA = 3'd4;

	// file header layout (positions within the 12-byte header)
	localparam logic [4:0] POS_GZIP_CHK = 5'd1;
	localparam logic [4:0] POS_ZSTD_CHK = 5'd3;
	localparam logic [4:0] POS_SIG_CHK  = 5'd6;
	localparam logic [4:0] POS_PTR      = 5'd7;
	localparam logic [4:0] POS_ORDER    = 5'd8;
	localparam logic [4:0] POS_VER0     = 5'd9;
	localparam logic [4:0] HDR_LAST_POS = 5'd11;

	// magics and marker characters, first byte in the low bits
	localparam logic [15:0] GZIP_MAGIC    = 16'h8B1F;
	localparam logic [31:0] ZSTD_MAGIC    = 32'hFD2FB528;
	localparam logic [55:0] SIG_WORD      = 56'h52_45_44_4E_45_4C_42;
	localparam logic [7:0]  PTR_WIDE_CHAR = 8'h2D;
	localparam logic [7:0]  BIG_END_CHAR  = 8'h56;
	localparam logic [31:0] CODE_ENDB     = 32'h42444E45;
	localparam logic [31:0] CODE_DNA1     = 32'h31414E44;

	// block header: size of the fixed part, without the pointer
	localparam logic [4:0] BLK_HDR_BASE = 5'd16;

	// one result item
	typedef struct packed {
		logic        record_valid;
		logic [31:0] block_code;
		logic [31:0] body_size;
		logic [63:0] old_address;
		logic [31:0] struct_number;
		logic [31:0] element_count;
		logic [31:0] body_start;
		logic        done_res;
		logic [2:0]  status;
		logic        wide_pointers;
		logic        big_endian;
		logic [23:0] version_chars;
	} bbiw_result_t;

endpackage

// File: design/bbiw_byte_if.sv
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one file byte per beat.
// ----------------------------------------------------------------------------
interface bbiw_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink   (input valid, input data_byte, input last, output ready);
endinterface

// File: design/bbiw_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one block record or end-of-walk status per beat.
// ----------------------------------------------------------------------------
interface bbiw_result_if;
	logic        valid;
	logic        ready;
	logic        record_valid;
	logic [31:0] block_code;
	logic [31:0] body_size;
	logic [63:0] old_address;
	logic [31:0] struct_number;
	logic [31:0] element_count;
	logic [31:0] body_start;
	logic        done_res;
	logic [2:0]  status;
	logic        wide_pointers;
	logic        big_endian;
	logic [23:0] version_chars;

	modport source (
		output valid, input ready,
		output record_valid, output block_code, output body_size, output old_address,
		output struct_number, output element_count, output body_start,
		output done_res, output status, output wide_pointers, output big_endian,
		output version_chars
	);
	modport sink (
		input valid, output ready,
		input record_valid, input block_code, input body_size, input old_address,
		input struct_number, input element_count, input body_start,
		input done_res, input status, input wide_pointers, input big_endian,
		input version_chars
	);
endinterface

// File: design/blend_block_index_walker.sv
// ----------------------------------------------------------------------------
// Block index walker
// Walks a blend-style container file byte by byte and reports each block
// header as a record, with a final status when the walk ends.
// ----------------------------------------------------------------------------
// The walker takes one file byte per clock on in_ch and needs no warm-up
// after reset. Each byte is handled by the front end, which keeps the
// whole walk state in registers; a record or end status it produces is
// registered into a 4-entry queue and shows on out_ch once it is the head
// entry. in_ch.ready stays high as long as the queue has a free entry, so
// with out_ch.ready held high the sustained rate is one byte per cycle;
// only a stalled output side that lets the queue fill throttles the input.
// Write file_length through cfg_wr_en/cfg_wr_data while no file is in
// flight.

module blend_block_index_walker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [31:0]   cfg_wr_data,
	bbiw_byte_if.sink     in_ch,
	bbiw_result_if.source out_ch
);
	import bbiw_pkg::*;

	logic [31:0]  file_length_q;
	logic         q_full;
	logic         push;
	bbiw_result_t push_data;

	// file length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
		end else if (cfg_wr_en) begin
			file_length_q <= cfg_wr_data;
		end
	end

	// parser
	bbiw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.file_length (file_length_q),
		.in_ch       (in_ch),
		.q_full      (q_full),
		.push        (push),
		.push_data   (push_data)
	);

	// result queue and output side
	bbiw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_ch    (out_ch)
	);

endmodule

// File: design/bbiw_front.sv
// ----------------------------------------------------------------------------
// Block index walker front end
// Takes one byte per beat, checks the file header, assembles block headers
// and pushes a record or end-of-walk status into the result queue.
// ----------------------------------------------------------------------------
`include "blend_block_index_walker_macros.svh"

module bbiw_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           file_length,
	bbiw_byte_if.sink             in_ch,
	input  logic                  q_full,
	output logic                  push,
	output bbiw_pkg::bbiw_result_t push_data
);
	import bbiw_pkg::*;

	// walk state
	phase_t                 phase_q;
	logic [4:0]             field_pos_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [31:0]            body_rem_q;
	logic [31:0]            code_q;
	logic [31:0]            size_q;
	logic [63:0]            addr_q;
	logic [31:0]            index_q;
	logic [31:0]            count_q;
	logic                   ptr_wide_q;
	logic                   big_end_q;
	logic [23:0]            version_q;
	logic                   dna_seen_q;

	// step results
	phase_t                 phase_n;
	logic [4:0]             pos_n;
	logic [31:0]            rem_n;
	logic [31:0]            code_n;
	logic [31:0]            size_n;
	logic [63:0]            addr_n;
	logic [31:0]            index_n;
	logic [31:0]            count_n;
	logic                   ptr_n;
	logic                   end_n;
	logic [23:0]            ver_n;
	logic                   dna_n;
	logic                   ended;
	logic                   record;
	logic [2:0]             stat;
	logic                   clear_walk;

	// helpers
	logic                   beat;
	logic [7:0]             b;
	logic                   lst;
	logic [1:0]             lane;
	logic [2:0]             lane8;
	logic [1:0]             ver_lane;
	logic [OFFSET_BITS-1:0] offset_inc;
	logic [63:0]            hdr_bytes;
	logic                   gzip_hit;
	logic                   zstd_hit;
	logic                   sig_bad;
	logic [4:0]             ptr_end;
	logic [4:0]             idx_end;
	logic [4:0]             cnt_end;
	logic [4:0]             blk_last;
	logic                   blk_done;
	logic                   clr;
	logic [31:0]            code_b;
	logic [31:0]            size_b;
	logic [63:0]            addr_b;
	logic [31:0]            index_b;
	logic [31:0]            count_b;
	logic [31:0]            fields_code;
	logic [31:0]            fields_size;
	logic [63:0]            fields_addr;
	logic [31:0]            fields_index;
	logic [31:0]            fields_count;
	logic                   overrun;
	logic [31:0]            rem_dec;

	// 32-bit field byte insert, shifting in when big-endian
	function automatic logic [31:0] take32(input logic [31:0] v, input logic [7:0] bv,
			input logic [1:0] ln, input logic big);
		return big ? {v[23:0], bv} : (v | (32'(bv) << {ln, 3'b000}));
	endfunction

	assign in_ch.ready = !q_full;
	assign beat        = in_ch.valid && in_ch.ready;
	assign b           = in_ch.data_byte;
	assign lst         = in_ch.last;
	assign lane        = field_pos_q[1:0];
	assign lane8       = field_pos_q[2:0];
	assign ver_lane    = 2'(field_pos_q - POS_VER0);
	assign offset_inc  = offset_q + 1'b1;

	// file header bytes as known after this beat
	always_comb begin
		hdr_bytes = addr_q;
		for (int i = 0; i < 8; i++) begin
			if (field_pos_q[4:3] == 2'b00 && lane8 == 3'(i)) begin
				hdr_bytes[8*i +: 8] = b;
			end
		end
	end

	assign gzip_hit = field_pos_q == POS_GZIP_CHK && hdr_bytes[15:0] == GZIP_MAGIC;
	assign zstd_hit = field_pos_q == POS_ZSTD_CHK && hdr_bytes[31:0] == ZSTD_MAGIC;
	assign sig_bad  = field_pos_q == POS_SIG_CHK && hdr_bytes[55:0] != SIG_WORD;

	// block header field boundaries
	assign ptr_end  = ptr_wide_q ? 5'd16 : 5'd12;
	assign idx_end  = ptr_end + 5'd4;
	assign cnt_end  = ptr_end + 5'd8;
	assign blk_last = ptr_end + BLK_HDR_BASE - 5'd9;
	assign blk_done = field_pos_q == blk_last;
	assign clr      = field_pos_q == 5'd0;

	assign code_b  = clr ? '0 : code_q;
	assign size_b  = clr ? '0 : size_q;
	assign addr_b  = clr ? '0 : addr_q;
	assign index_b = clr ? '0 : index_q;
	assign count_b = clr ? '0 : count_q;

	// block header field assembly
	always_comb begin
		fields_code  = code_b;
		fields_size  = size_b;
		fields_addr  = addr_b;
		fields_index = index_b;
		fields_count = count_b;
		if (field_pos_q < 5'd4) begin
			fields_code = code_b | (32'(b) << {lane, 3'b000});
		end else if (field_pos_q < 5'd8) begin
			fields_size = take32(size_b, b, lane, big_end_q);
		end else if (field_pos_q < ptr_end) begin
			fields_addr = big_end_q ? {addr_b[55:0], b} : (addr_b | (64'(b) << {lane8, 3'b000}));
		end else if (field_pos_q < idx_end) begin
			fields_index = take32(index_b, b, lane, big_end_q);
		end else if (field_pos_q < cnt_end) begin
			fields_count = take32(count_b, b, lane, big_end_q);
		end
	end

	// body must end within the configured file length
	assign overrun = fields_size > file_length ||
		64'(offset_inc) > 64'(file_length - fields_size);
	assign rem_dec = (body_rem_q != 32'd0) ? body_rem_q - 32'd1 : body_rem_q;

	// per-beat walk step
	always_comb begin
		phase_n = phase_q;
		pos_n   = field_pos_q;
		rem_n   = body_rem_q;
		code_n  = code_q;
		size_n  = size_q;
		addr_n  = addr_q;
		index_n = index_q;
		count_n = count_q;
		ptr_n   = ptr_wide_q;
		end_n   = big_end_q;
		ver_n   = version_q;
		dna_n   = dna_seen_q;
		ended   = 1'b0;
		record  = 1'b0;
		stat    = ST_OK;
		case (phase_q)
			PH_HEADER: begin
				addr_n = hdr_bytes;
				if (gzip_hit) begin
					ended = 1'b1;
					stat  = ST_GZIP;
				end else if (zstd_hit) begin
					ended = 1'b1;
					stat  = ST_ZSTD;
				end else if (sig_bad) begin
					ended = 1'b1;
					stat  = ST_NO_SIG;
				end
				if (!ended) begin
					if (field_pos_q == POS_PTR) begin
						ptr_n = b == PTR_WIDE_CHAR;
					end else if (field_pos_q == POS_ORDER) begin
						end_n = b == BIG_END_CHAR;
					end else if (field_pos_q >= POS_VER0 && field_pos_q <= HDR_LAST_POS) begin
						ver_n = version_q | (24'(b) << {ver_lane, 3'b000});
					end
					if (field_pos_q >= HDR_LAST_POS) begin
						phase_n = PH_BLOCK;
						pos_n   = 5'd0;
						if (lst) begin
							ended = 1'b1;
							stat  = dna_seen_q ? ST_OK : ST_NO_SDNA;
						end
					end else begin
						pos_n = field_pos_q + 5'd1;
						if (lst) begin
							ended = 1'b1;
							stat  = ST_NO_SIG;
						end
					end
				end
			end
			PH_BLOCK: begin
				code_n  = fields_code;
				size_n  = fields_size;
				addr_n  = fields_addr;
				index_n = fields_index;
				count_n = fields_count;
				if (blk_done) begin
					pos_n = 5'd0;
					if (overrun) begin
						ended = 1'b1;
						stat  = dna_seen_q ? ST_OK : ST_NO_SDNA;
					end else begin
						record = 1'b1;
						if (fields_code == CODE_ENDB) begin
							ended = 1'b1;
						end else begin
							if (fields_code == CODE_DNA1) begin
								dna_n = 1'b1;
							end
							if (fields_size != 32'd0) begin
								phase_n = PH_BODY;
								rem_n   = fields_size;
							end
							ended = lst;
						end
						stat = dna_n ? ST_OK : ST_NO_SDNA;
					end
				end else begin
					pos_n = field_pos_q + 5'd1;
					if (lst) begin
						ended = 1'b1;
						stat  = dna_seen_q ? ST_OK : ST_NO_SDNA;
					end
				end
			end
			PH_BODY: begin
				rem_n = rem_dec;
				if (rem_dec == 32'd0) begin
					phase_n = PH_BLOCK;
					pos_n   = 5'd0;
				end
				if (lst) begin
					ended = 1'b1;
					stat  = dna_seen_q ? ST_OK : ST_NO_SDNA;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_HEADER;
			end
		endcase
		if (ended) begin
			phase_n = PH_DONE;
		end
	end

	// a walk that ends on the last byte, or a swallowed last byte, re-arms
	assign clear_walk = lst && (ended || phase_q == PH_DONE);

	// result item
	always_comb begin
		push_data               = '0;
		push_data.wide_pointers = ptr_n;
		push_data.big_endian    = end_n;
		push_data.version_chars = ver_n;
		if (record) begin
			push_data.record_valid  = 1'b1;
			push_data.block_code    = fields_code;
			push_data.body_size     = fields_size;
			push_data.old_address   = fields_addr;
			push_data.struct_number = fields_index;
			push_data.element_count = fields_count;
			push_data.body_start    = 32'(offset_inc);
		end
		if (ended) begin
			push_data.done_res = 1'b1;
			push_data.status   = stat;
		end
	end

	assign push = beat && (ended || record);

	// walk state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			field_pos_q <= '0;
			offset_q    <= '0;
			body_rem_q  <= '0;
			code_q      <= '0;
			size_q      <= '0;
			addr_q      <= '0;
			index_q     <= '0;
			count_q     <= '0;
			ptr_wide_q  <= 1'b0;
			big_end_q   <= 1'b0;
			version_q   <= '0;
			dna_seen_q  <= 1'b0;
		end else if (beat) begin
			if (clear_walk) begin
				phase_q     <= PH_HEADER;
				field_pos_q <= '0;
				offset_q    <= '0;
				body_rem_q  <= '0;
				code_q      <= '0;
				size_q      <= '0;
				addr_q      <= '0;
				index_q     <= '0;
				count_q     <= '0;
				ptr_wide_q  <= 1'b0;
				big_end_q   <= 1'b0;
				version_q   <= '0;
				dna_seen_q  <= 1'b0;
			end else begin
				phase_q     <= phase_n;
				field_pos_q <= pos_n;
				if (phase_q != PH_DONE) begin
					offset_q <= offset_inc;
				end
				body_rem_q  <= rem_n;
				code_q      <= code_n;
				size_q      <= size_n;
				addr_q      <= addr_n;
				index_q     <= index_n;
				count_q     <= count_n;
				ptr_wide_q  <= ptr_n;
				big_end_q   <= end_n;
				version_q   <= ver_n;
				dna_seen_q  <= dna_n;
			end
		end
	end

	// checks
	`BBIW_ASSERT(a_body_end_to_block, beat && phase_q == PH_BODY && body_rem_q == 32'd1 && !in_ch.last |=> phase_q == PH_BLOCK && field_pos_q == 5'd0, "body end did not return to block header")
	`BBIW_ASSERT(a_end_leaves_walk, push && push_data.done_res |=> phase_q == PH_DONE || phase_q == PH_HEADER, "walk continued after its end")
	`BBIW_ASSERT(a_offset_step, beat && phase_q != PH_DONE && !in_ch.last |=> offset_q == OFFSET_BITS'($past(offset_q) + 1'b1), "byte offset did not advance by one")
	`BBIW_ASSERT_NEVER(a_record_outside_block, push && push_data.record_valid && phase_q != PH_BLOCK, "record pushed outside block header phase")

endmodule

// File: design/bbiw_queue.sv
// ----------------------------------------------------------------------------
// Block index walker result queue
// Short FIFO between the parser and the output channel so each side can
// stall on its own; the head entry drives the output channel.
// ----------------------------------------------------------------------------
`include "blend_block_index_walker_macros.svh"

module bbiw_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  bbiw_pkg::bbiw_result_t push_data,
	output logic                   full,
	bbiw_result_if.source          out_ch
);
	import bbiw_pkg::*;

	bbiw_result_t      entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              pop;
	bbiw_result_t      head;

	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop   = out_ch.valid && out_ch.ready;
	assign head  = entry_q[rd_ptr_q];

	// head entry onto the channel
	assign out_ch.valid         = count_q != '0;
	assign out_ch.record_valid  = head.record_valid;
	assign out_ch.block_code    = head.block_code;
	assign out_ch.body_size     = head.body_size;
	assign out_ch.old_address   = head.old_address;
	assign out_ch.struct_number = head.struct_number;
	assign out_ch.element_count = head.element_count;
	assign out_ch.body_start    = head.body_start;
	assign out_ch.done_res      = head.done_res;
	assign out_ch.status        = head.status;
	assign out_ch.wide_pointers = head.wide_pointers;
	assign out_ch.big_endian    = head.big_endian;
	assign out_ch.version_chars = head.version_chars;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	`BBIW_ASSERT_NEVER(a_no_overflow, push && full, "push into a full queue")
	`BBIW_ASSERT(a_fill_up, push && !pop |=> count_q == (QPTR_W+1)'($past(count_q) + 1'b1), "fill level missed a push")
	`BBIW_ASSERT(a_fill_down, pop && !push |=> count_q == (QPTR_W+1)'($past(count_q) - 1'b1), "fill level missed a pop")

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block index walker testbench
// Streams container files byte by byte into the walker and checks every
// record and end status against an in-bench model of the walk. A short
// directed run covers the magics and short headers. Random well-formed
// files follow, mixed with broken ones, under several file_length settings
// and with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import bbiw_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} file_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	bbiw_byte_if   byte_ch ();
	bbiw_result_if result_ch ();

	blend_block_index_walker dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (byte_ch),
		.out_ch      (result_ch)
	);

	// stimulus and expected results
	file_beat_t   beat_q[$];
	bbiw_result_t result_due_q[$];
	logic [7:0]   file_buf[$];
	file_beat_t   next_beat;

	int mismatch_count = 0;
	int bytes_total    = 0;
	int results_total  = 0;
	int send_gap       = 0;
	int stall_left     = 0;
	bit idle_on        = 1'b0;
	bit stall_req      = 1'b0;

	// walk state of the model
	logic [31:0]            cfg_file_length;
	phase_t                 walk_phase;
	logic [4:0]             walk_pos;
	logic [OFFSET_BITS-1:0] walk_offset;
	logic [31:0]            walk_left;
	logic [31:0]            hdr_code, hdr_size, hdr_sdna, hdr_count;
	logic [63:0]            hdr_addr;
	logic                   walk_wide, walk_big, walk_dna;
	logic [23:0]            walk_ver;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("FAIL blend_block_index_walker");
		$finish;
	end

	// ---------------------------------------------------------------- model

	task automatic walk_clear();
		walk_phase  = PH_HEADER;
		walk_pos    = '0;
		walk_offset = '0;
		walk_left   = '0;
		hdr_code    = '0;
		hdr_size    = '0;
		hdr_sdna    = '0;
		hdr_count   = '0;
		hdr_addr    = '0;
		walk_wide   = 1'b0;
		walk_big    = 1'b0;
		walk_dna    = 1'b0;
		walk_ver    = '0;
	endtask

	// 32-bit field assembly: shift in when big-endian, else place by byte index
	function automatic logic [31:0] take_word(logic [31:0] v, logic [7:0] b, int k, logic big);
		if (big)
			return {v[23:0], b};
		return v | (32'(b) << (8 * (k & 3)));
	endfunction

	// advance the walk by one byte; queue the result it causes, if any
	task automatic walk_byte(input logic [7:0] b, input logic lst);
		bbiw_result_t           res;
		logic [4:0]             p;
		logic                   ended, rec;
		logic [2:0]             st;
		logic [OFFSET_BITS-1:0] start;
		logic [63:0]            start_wide;
		int unsigned            psz;
		res        = '0;
		p          = walk_pos;
		ended      = 1'b0;
		rec        = 1'b0;
		st         = ST_OK;
		start      = walk_offset + 1'b1;
		start_wide = 64'(start);
		psz        = walk_wide ? 8 : 4;
		if (walk_phase == PH_DONE) begin
			// swallow until the end of this file
			if (lst)
				walk_clear();
		end else begin
			case (walk_phase)
				PH_HEADER: begin
					if (p < 8)
						hdr_addr[8 * p +: 8] = b;
					if (p == POS_GZIP_CHK && hdr_addr[15:0] == GZIP_MAGIC) begin
						ended = 1'b1;
						st    = ST_GZIP;
					end else if (p == POS_ZSTD_CHK && hdr_addr[31:0] == ZSTD_MAGIC) begin
						ended = 1'b1;
						st    = ST_ZSTD;
					end else if (p == POS_SIG_CHK && hdr_addr[55:0] != SIG_WORD) begin
						ended = 1'b1;
						st    = ST_NO_SIG;
					end
					if (!ended) begin
						if (p == POS_PTR)
							walk_wide = (b == PTR_WIDE_CHAR);
						else if (p == POS_ORDER)
							walk_big = (b == BIG_END_CHAR);
						else if (p >= POS_VER0)
							walk_ver[8 * (p - POS_VER0) +: 8] = b;
						if (p >= HDR_LAST_POS) begin
							walk_phase = PH_BLOCK;
							walk_pos   = '0;
							if (lst) begin
								ended = 1'b1;
								st    = walk_dna ? ST_OK : ST_NO_SDNA;
							end
						end else begin
							walk_pos = p + 1'b1;
							if (lst) begin
								ended = 1'b1;
								st    = ST_NO_SIG;
							end
						end
					end
				end
				PH_BLOCK: begin
					if (p == 0) begin
						hdr_code  = '0;
						hdr_size  = '0;
						hdr_sdna  = '0;
						hdr_count = '0;
						hdr_addr  = '0;
					end
					if (p < 4)
						hdr_code[8 * p +: 8] = b;
					else if (p < 8)
						hdr_size = take_word(hdr_size, b, p - 4, walk_big);
					else if (p < 8 + psz) begin
						if (walk_big)
							hdr_addr = {hdr_addr[55:0], b};
						else
							hdr_addr[8 * ((p - 8) & 7) +: 8] = b;
					end else if (p < 12 + psz)
						hdr_sdna = take_word(hdr_sdna, b, p - 8 - psz, walk_big);
					else if (p < 16 + psz)
						hdr_count = take_word(hdr_count, b, p - 12 - psz, walk_big);

					if (p + 1 >= BLK_HDR_BASE + psz) begin
						walk_pos = '0;
						// body running past the file end: stop without a record
						if (hdr_size > cfg_file_length ||
								start_wide > cfg_file_length - hdr_size) begin
							ended = 1'b1;
							st    = walk_dna ? ST_OK : ST_NO_SDNA;
						end else begin
							rec               = 1'b1;
							res.record_valid  = 1'b1;
							res.block_code    = hdr_code;
							res.body_size     = hdr_size;
							res.old_address   = hdr_addr;
							res.struct_number = hdr_sdna;
							res.element_count = hdr_count;
							res.body_start    = 32'(start);
							if (hdr_code == CODE_ENDB)
								ended = 1'b1;
							else begin
								if (hdr_code == CODE_DNA1)
									walk_dna = 1'b1;
								if (hdr_size != 0) begin
									walk_phase = PH_BODY;
									walk_left  = hdr_size;
								end
								if (lst)
									ended = 1'b1;
							end
							st = walk_dna ? ST_OK : ST_NO_SDNA;
						end
					end else begin
						walk_pos = p + 1'b1;
						if (lst) begin
							ended = 1'b1;
							st    = walk_dna ? ST_OK : ST_NO_SDNA;
						end
					end
				end
				default: begin
					// body bytes are skipped
					if (walk_left != 0)
						walk_left--;
					if (walk_left == 0) begin
						walk_phase = PH_BLOCK;
						walk_pos   = '0;
					end
					if (lst) begin
						ended = 1'b1;
						st    = walk_dna ? ST_OK : ST_NO_SDNA;
					end
				end
			endcase
			walk_offset = start;
			if (ended || rec) begin
				res.wide_pointers = walk_wide;
				res.big_endian    = walk_big;
				res.version_chars = walk_ver;
				if (ended) begin
					res.done_res = 1'b1;
					res.status   = st;
					if (lst)
						walk_clear();
					else
						walk_phase = PH_DONE;
				end
				result_due_q.insert(result_due_q.size(), res);
				results_total++;
			end
		end
	endtask

	// ------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatch_count < 40)
			$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic check_beat();
		bbiw_result_t want;
		if (result_due_q.size() == 0)
			report_mismatch("unexpected beat", 64'(result_ch.block_code), 64'd0);
		else begin
			want = result_due_q.pop_front();
			check_field("record_valid", 64'(result_ch.record_valid), 64'(want.record_valid));
			check_field("block_code", 64'(result_ch.block_code), 64'(want.block_code));
			check_field("body_size", 64'(result_ch.body_size), 64'(want.body_size));
			check_field("old_address", result_ch.old_address, want.old_address);
			check_field("struct_number", 64'(result_ch.struct_number),
				64'(want.struct_number));
			check_field("element_count", 64'(result_ch.element_count),
				64'(want.element_count));
			check_field("body_start", 64'(result_ch.body_start), 64'(want.body_start));
			check_field("done_res", 64'(result_ch.done_res), 64'(want.done_res));
			check_field("status", 64'(result_ch.status), 64'(want.status));
			check_field("wide_pointers", 64'(result_ch.wide_pointers),
				64'(want.wide_pointers));
			check_field("big_endian", 64'(result_ch.big_endian), 64'(want.big_endian));
			check_field("version_chars", 64'(result_ch.version_chars),
				64'(want.version_chars));
		end
	endtask

	// --------------------------------------------------------------- driver

	// each byte is run through the model when first offered; it stays
	// offered until taken, so the order matches the accepted order
	always @(posedge clk) begin
		if (arst_n) begin
			if (!byte_ch.valid || byte_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					byte_ch.valid <= 1'b0;
				end else if (beat_q.size() != 0) begin
					next_beat = beat_q.pop_front();
					walk_byte(next_beat.data, next_beat.last);
					byte_ch.valid     <= 1'b1;
					byte_ch.data_byte <= next_beat.data;
					byte_ch.last      <= next_beat.last;
					if (idle_on && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 9);
				end else
					byte_ch.valid <= 1'b0;
			end
		end
	end

	// -------------------------------------------------------------- monitor

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready)
				check_beat();
			// result side back-pressure
			if (stall_left != 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (stall_req) begin
				stall_req  = 1'b0;
				stall_left = 199;
				result_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 8);
				result_ch.ready <= 1'b0;
			end else
				result_ch.ready <= 1'b1;
		end
	end

	// ------------------------------------------------------- file generation

	task automatic put_byte(input logic [7:0] v);
		file_buf.insert(file_buf.size(), v);
	endtask

	task automatic put_word(input logic [63:0] v, input int n, input logic big);
		for (int i = 0; i < n; i++)
			put_byte(big ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8]);
	endtask

	task automatic put_header(input logic wide, input logic big);
		logic [7:0] c;
		put_word(64'(SIG_WORD), 7, 1'b0);
		c = 8'($urandom);
		if (c == PTR_WIDE_CHAR)
			c = 8'h5F;
		put_byte(wide ? PTR_WIDE_CHAR : c);
		c = 8'($urandom);
		if (c == BIG_END_CHAR)
			c = 8'h76;
		put_byte(big ? BIG_END_CHAR : c);
		repeat (3) begin
			c = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
				8'(8'h30 + $urandom_range(0, 9));
			put_byte(c);
		end
	endtask

	// block header only: code, size, address, struct index, count
	task automatic put_block(input logic [31:0] code, input logic [31:0] size,
			input logic wide, input logic big);
		put_word(64'(code), 4, 1'b0);
		put_word(64'(size), 4, big);
		put_word({$urandom, $urandom}, wide ? 8 : 4, big);
		put_word(64'($urandom), 4, big);
		put_word(64'($urandom), 4, big);
	endtask

	// well-formed file, possibly cut short or ending in an overrun
	task automatic add_blend_file(input logic [31:0] len);
		logic        wide, big, cut;
		logic [31:0] code, size;
		logic [63:0] start;
		int          nblk, hsz, body_len;
		wide = 1'($urandom_range(0, 1));
		big  = 1'($urandom_range(0, 1));
		cut  = 1'b0;
		hsz  = wide ? 24 : 20;
		put_header(wide, big);
		nblk = $urandom_range(0, 5);
		for (int k = 0; k < nblk && !cut; k++) begin
			case ($urandom_range(0, 9))
				0, 1:    code = CODE_DNA1;
				2:       code = CODE_ENDB;
				default: code = $urandom;
			endcase
			start = 64'(file_buf.size() + hsz);
			case ($urandom_range(0, 9))
				0: size = 0;
				// body ending exactly at file_length
				6: size = (len >= start && len - start <= 48) ? 32'(len - start) : 32'd0;
				// one byte too long
				7: size = 32'(len - start + 1);
				8: size = 32'hFFFF_FFFF - $urandom_range(0, 15);
				default: size = $urandom_range(1, 12);
			endcase
			put_block(code, size, wide, big);
			if (size > len || start > len - size) begin
				body_len = $urandom_range(0, 4);
				cut      = 1'b1;
			end else if (code == CODE_ENDB) begin
				body_len = $urandom_range(0, 3);
				cut      = 1'b1;
			end else if (size > 1 && $urandom_range(0, 7) == 0) begin
				// file ends inside a body
				body_len = $urandom_range(1, size - 1);
				cut      = 1'b1;
			end else
				body_len = size;
			repeat (body_len) put_byte(8'($urandom));
		end
		if (!cut) begin
			case ($urandom_range(0, 3))
				0: ;
				1: put_block(CODE_ENDB, 0, wide, big);
				2: begin
					// incomplete block header at the end
					put_block($urandom, $urandom_range(0, 12), wide, big);
					repeat ($urandom_range(1, hsz - 1)) void'(file_buf.pop_back());
				end
				default: begin
					put_block(CODE_ENDB, 0, wide, big);
					repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
				end
			endcase
		end
	endtask

	// compressed magics, bad signatures, short headers and plain noise
	task automatic add_broken_file();
		int n;
		case ($urandom_range(0, 4))
			0: begin
				put_word(64'(GZIP_MAGIC), 2, 1'b0);
				repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
			end
			1: begin
				put_word(64'(ZSTD_MAGIC), 4, 1'b0);
				repeat ($urandom_range(0, 4)) put_byte(8'($urandom));
			end
			2: begin
				put_word(64'(SIG_WORD), 7, 1'b0);
				n = $urandom_range(0, 6);
				file_buf[n] = file_buf[n] ^ 8'($urandom_range(1, 255));
				repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
			end
			3: begin
				put_header(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				n = $urandom_range(1, 11);
				while (file_buf.size() > n)
					void'(file_buf.pop_back());
			end
			default: repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
		endcase
	endtask

	// move the built file into the byte queue, last flag on its final byte
	task automatic ship_file();
		file_beat_t fb;
		foreach (file_buf[i]) begin
			fb.data = file_buf[i];
			fb.last = (i == file_buf.size() - 1);
			beat_q.insert(beat_q.size(), fb);
		end
		bytes_total += file_buf.size();
		file_buf.delete();
	endtask

	// ------------------------------------------------------------- sequence

	task automatic wait_drained(input int settle);
		while (beat_q.size() != 0 || byte_ch.valid || result_due_q.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_length(input logic [31:0] len);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		cfg_file_length = len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		logic [31:0] len;
		int          mark;
		int          nfile;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last      = 1'b0;
		result_ch.ready   = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_wr_data       = '0;
		cfg_file_length   = '0;
		walk_clear();
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: gzip then a swallowed byte, zstd ending on last,
		// a lone byte, a bad signature, a header cut after the pointer char
		put_word(64'(GZIP_MAGIC), 2, 1'b0);
		put_byte(8'h00);
		ship_file();
		put_word(64'(ZSTD_MAGIC), 4, 1'b0);
		ship_file();
		put_byte(8'hFF);
		ship_file();
		put_word(64'(SIG_WORD), 6, 1'b0);
		put_byte(8'h51);
		put_byte(8'h7F);
		put_byte(8'h80);
		ship_file();
		put_word(64'(SIG_WORD), 7, 1'b0);
		put_byte(PTR_WIDE_CHAR);
		ship_file();

		// random phases under several file lengths
		for (int ph = 0; ph < 24 && !(ph >= 5 && bytes_total >= 650 && results_total >= 60);
				ph++) begin
			wait_drained(8);
			case (ph % 4)
				0:       len = 32'hFFFF_FFFF;
				1:       len = 32'h0;
				2:       len = $urandom_range(48, 320);
				default: len = $urandom;
			endcase
			write_length(len);
			idle_on = (ph % 3 != 0);
			// long result-side hold while bytes keep coming
			if (ph == 0)
				stall_req = 1'b1;
			mark  = bytes_total;
			nfile = 0;
			while (bytes_total - mark < 100) begin
				// sender waits for all results once
				if (ph % 4 == 2 && nfile == 2)
					wait_drained($urandom_range(0, 12));
				if ($urandom_range(0, 4) == 0)
					add_broken_file();
				else
					add_blend_file(len);
				ship_file();
				nfile++;
			end
		end

		// closing stretch with no idling
		wait_drained(8);
		len = 32'hFFFF_FFFF;
		write_length(len);
		idle_on = 1'b0;
		mark    = bytes_total;
		while (bytes_total - mark < 50) begin
			add_blend_file(len);
			ship_file();
		end

		wait_drained(16);
		if (mismatch_count == 0)
			$display("PASS blend_block_index_walker");
		else
			$display("FAIL blend_block_index_walker");
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/bbiw_pkg.sv
design/bbiw_byte_if.sv
design/bbiw_result_if.sv
design/bbiw_front.sv
design/bbiw_queue.sv
design/blend_block_index_walker.sv
test/testbench.sv
